FILE: src/owal_pkg.sv
package owal_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned LimitWidth = 31;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumWheels = 4;
  localparam int unsigned CBits = 20;

  localparam logic signed [25:0] KDiag = 26'sd741343;
  localparam logic signed [25:0] KArm = 26'sd21286093;
  localparam logic signed [25:0] KInvArm4 = 26'sd12913;
  localparam logic signed [25:0] KInvDiag2 = 26'sd370784;
  localparam logic signed [25:0] KSpin = 26'sd31457;
  localparam logic signed [25:0] KConv = 26'sd104858;

  localparam logic CfgIdxLimit = 1'b0;
  localparam logic CfgIdxConv = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MAP,
    ST_WHEEL,
    ST_ACMP,
    ST_ADIV,
    ST_AMUL,
    ST_BODY,
    ST_SQ,
    ST_SQRT,
    ST_SPIN,
    ST_SMAX,
    ST_SDIV,
    ST_BODY2,
    ST_CONV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  function automatic logic signed [63:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 64'sd2147483647;
    else if (v < -66'sd2147483648) return -64'sd2147483648;
    else return v[63:0];
  endfunction

endpackage

FILE: src/omni_wheel_accel_limiter.sv
// the time from the command transfer to result valid is set by the
// 32-step root and, when clipping, a divide per wheel (up to eight divisions)
// not ready while an item is in work; a new command waits until the last is done
// the result register holds until taken; the next command is taken meanwhile
// reset: async active low; limit 30.0, correction off, stored wheel speeds zero
module omni_wheel_accel_limiter #(
  parameter int unsigned FRAC_BITS = owal_pkg::FracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  cmd_vx_i,
  input  logic signed [31:0]  cmd_vy_i,
  input  logic signed [31:0]  cmd_turn_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  lim_vx_o,
  output logic signed [31:0]  lim_vy_o,
  output logic signed [31:0]  lim_turn_o,
  output logic                accel_clipped_o,
  output logic                spin_clipped_o
);
  import owal_pkg::*;

  state_e state_q, state_d;
  logic [30:0] lim_q;
  logic conv_q;
  logic signed [31:0] prev_q [NumWheels];
  logic signed [31:0] ws_q [NumWheels], ws_d [NumWheels];
  logic signed [32:0] acc_q [NumWheels], acc_d [NumWheels];
  logic [1:0] c_q [NumWheels], c_d [NumWheels];
  logic signed [31:0] vx_q, vy_q, w_q, vx_d, vy_d, w_d;
  logic [1:0] idx_q, idx_d, best_q, best_d;
  logic [3:0] sub_q, sub_d;
  logic aclip_q, aclip_d, sclip_q, sclip_d;
  logic [63:0] t0_q, t0_d, t1_q, t1_d;
  logic [31:0] r_q, r_d, vmax_q, vmax_d;
  logic ovalid_q, ovalid_d;
  logic signed [31:0] ovx_q, ovy_q, ow_q;
  logic oac_q, osc_q;

  div_ctl_t dctl;
  logic [63:0] dnum, dden, dquo;
  logic dbusy;

  // shared multiplier
  logic signed [35:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  owal_div u_div (
    .clk_i, .rst_ni, .ctl_i(dctl), .num_i(dnum), .den_i(dden),
    .quo_o(dquo), .busy_o(dbusy)
  );

  function automatic logic signed [65:0] fsh(input logic signed [65:0] x,
                                             input int unsigned n);
    return x >>> n;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

  logic in_acc, out_acc;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o = state_q != ST_IDLE;
  assign cfg_ready_o = 1'b1;

  logic signed [65:0] rnd_c, rnd_f;
  logic signed [34:0] sum4;
  logic [32:0] mi, mb_mag;
  logic signed [31:0] oprev;

  assign rnd_c = fsh(mp + (66'sd1 <<< (CBits - 1)), CBits);
  assign rnd_f = fsh(mp + (66'sd1 <<< (FRAC_BITS - 1)), FRAC_BITS);

  always_comb begin
    state_d = state_q;
    ws_d = ws_q; acc_d = acc_q; c_d = c_q;
    vx_d = vx_q; vy_d = vy_q; w_d = w_q;
    idx_d = idx_q; best_d = best_q; sub_d = sub_q;
    aclip_d = aclip_q; sclip_d = sclip_q;
    t0_d = t0_q; t1_d = t1_q; r_d = r_q; vmax_d = vmax_q;
    ovalid_d = ovalid_q && !out_acc;
    ma = '0; mb = '0;
    dctl = '0; dnum = '0; dden = '0;
    sum4 = '0; mi = '0; mb_mag = '0; oprev = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          vx_d = cmd_vx_i; vy_d = cmd_vy_i; w_d = cmd_turn_i;
          sub_d = '0; state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        // sub 0: a, 1: b, 2: t
        case (sub_q)
          4'd0: begin ma = 36'(vx_q) - 36'(vy_q); mb = 33'(KDiag); t0_d = 64'(rnd_c); end
          4'd1: begin ma = 36'(vx_q) + 36'(vy_q); mb = 33'(KDiag); t1_d = 64'(rnd_c); end
          default: begin
            ma = 36'(w_q); mb = 33'(KArm);
            ws_d[0] = 32'(sat32(66'($signed(t0_q)) - rnd_c));
            ws_d[1] = 32'(sat32(66'($signed(t1_q)) - rnd_c));
            ws_d[2] = 32'(sat32(-66'($signed(t1_q)) - rnd_c));
            ws_d[3] = 32'(sat32(-66'($signed(t0_q)) - rnd_c));
          end
        endcase
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd2) begin idx_d = '0; best_d = '0; state_d = ST_WHEEL; end
      end
      ST_WHEEL: begin
        oprev = prev_q[idx_q];
        acc_d[idx_q] = 33'(ws_q[idx_q]) - 33'(oprev);
        c_d[idx_q] = ((acc_d[idx_q] < 0 && oprev > 0) ||
                      (acc_d[idx_q] > 0 && oprev < 0)) ? 2'd3 : 2'd2;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin idx_d = 2'd1; state_d = ST_ACMP; end
      end
      ST_ACMP: begin
        mi = mag33(acc_q[idx_q]);
        mb_mag = mag33(acc_q[best_q]);
        if (35'(mi) * 35'(c_q[best_q]) > 35'(mb_mag) * 35'(c_q[idx_q])) best_d = idx_q;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          state_d = ST_AMUL; sub_d = 4'd0; idx_d = '0;
        end
      end
      ST_AMUL: begin
        mb_mag = mag33(acc_q[best_q]);
        if (sub_q == 4'd0) begin
          aclip_d = {1'b0, mb_mag, 1'b0} > 35'(c_q[best_q]) * 35'(lim_q);
          sub_d = 4'd1;
          if (!({1'b0, mb_mag, 1'b0} > 35'(c_q[best_q]) * 35'(lim_q))) begin
            sub_d = '0; state_d = ST_BODY;
          end
        end else if (sub_q == 4'd1) begin
          dctl.start = 1'b1;
          dnum = 64'(mag33(acc_q[idx_q])) << 30;
          dden = 64'(mb_mag);
          sub_d = 4'd2;
        end else if (sub_q == 4'd2) begin
          if (!dbusy) begin
            ma = 36'(dquo); mb = 33'(c_q[best_q]); t0_d = 64'(mp); sub_d = 4'd3;
          end
        end else begin
          ma = 36'(t0_q); mb = 33'(lim_q);
          t1_d = 64'((mp + (66'sd1 <<< 30)) >>> 31);
          ws_d[idx_q] = 32'(sat32(66'(prev_q[idx_q]) +
                        (acc_q[idx_q][32] ? -66'(t1_d) : 66'(t1_d))));
          sub_d = 4'd1;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) begin sub_d = '0; state_d = ST_BODY; end
        end
      end
      ST_BODY, ST_BODY2: begin
        case (sub_q)
          4'd0: begin
            sum4 = -(35'(ws_q[0]) + 35'(ws_q[1]) + 35'(ws_q[2]) + 35'(ws_q[3]));
            ma = 36'(sum4); mb = 33'(KInvArm4); w_d = 32'(sat32(rnd_c));
          end
          4'd1: begin
            sum4 = 35'(ws_q[0]) + 35'(ws_q[1]) - 35'(ws_q[2]) - 35'(ws_q[3]);
            ma = 36'(sum4); mb = 33'(KInvDiag2); vx_d = 32'(sat32(rnd_c));
          end
          default: begin
            sum4 = 35'(ws_q[1]) + 35'(ws_q[2]) - 35'(ws_q[0]) - 35'(ws_q[3]);
            ma = 36'(sum4); mb = 33'(KInvDiag2); vy_d = 32'(sat32(rnd_c));
          end
        endcase
        sub_d = sub_q + 4'd1;
        if (sub_q == 4'd2) begin
          sub_d = '0;
          state_d = (state_q == ST_BODY) ? ST_SQ : ST_CONV;
        end
      end
      ST_SQ: begin
        if (sub_q == 4'd0) begin
          ma = 36'(vx_q); mb = 33'(vx_q); t0_d = 64'(mp); sub_d = 4'd1;
        end else begin
          ma = 36'(vy_q); mb = 33'(vy_q); t0_d = t0_q + 64'(mp);
          t1_d = '0; r_d = '0; idx_d = '0; sub_d = '0;
          vmax_d = 32'd31; state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // radix-4 digit per cycle, 32 steps; t1 holds remainder bits
        begin
          logic [65:0] rem, trial;
          rem = {t1_q[63:0], t0_q[63:62]};
          trial = rem - {32'd0, r_q, 2'b01};
          if (!trial[65]) begin
            t1_d = trial[63:0]; r_d = {r_q[30:0], 1'b1};
          end else begin
            t1_d = rem[63:0]; r_d = {r_q[30:0], 1'b0};
          end
          t0_d = {t0_q[61:0], 2'b00};
        end
        vmax_d = vmax_q - 32'd1;
        if (vmax_q == 32'd0) state_d = ST_SPIN;
      end
      ST_SPIN: begin
        if (sub_q == 4'd0) begin
          ma = 36'(mag33(33'(w_q))); mb = 33'(KSpin);
          t0_d = 64'((mp + (66'sd1 <<< (CBits - 1))) >>> CBits); sub_d = 4'd1;
        end else begin
          ma = 36'(r_q); mb = 33'(t0_q);
          sclip_d = mp > (66'(lim_q) <<< FRAC_BITS);
          sub_d = '0; idx_d = '0; vmax_d = 32'(lim_q);
          state_d = (mp > (66'(lim_q) <<< FRAC_BITS)) ? ST_SMAX : ST_CONV;
        end
      end
      ST_SMAX: begin
        mi = mag33(33'(ws_q[idx_q]));
        if (mi > 33'(vmax_q)) vmax_d = mi[31:0];
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          sub_d = '0;
          if (vmax_d == 32'd0) state_d = ST_BODY2;
          else state_d = ST_SDIV;
        end
      end
      ST_SDIV: begin
        mi = mag33(33'(ws_q[idx_q]));
        if (sub_q == 4'd0) begin
          ma = 36'(mi); mb = 33'(lim_q); t0_d = 64'(mp); sub_d = 4'd1;
        end else if (sub_q == 4'd1) begin
          dctl.start = 1'b1; dnum = t0_q; dden = 64'(vmax_q); sub_d = 4'd2;
        end else if (!dbusy) begin
          ws_d[idx_q] = 32'(sat32(ws_q[idx_q][31] ? 66'(ws_q[idx_q]) + 66'(dquo)
                                                  : 66'(ws_q[idx_q]) - 66'(dquo)));
          sub_d = '0; idx_d = idx_q + 2'd1;
          if (idx_q == 2'd3) state_d = ST_BODY2;
        end
      end
      ST_CONV: begin
        if (!conv_q) state_d = ST_OUT;
        else if (sub_q == 4'd0) begin
          ma = 36'(w_q); mb = 33'(KConv); t0_d = 64'(rnd_c); sub_d = 4'd1;
        end else if (sub_q == 4'd1) begin
          ma = 36'(vy_q); mb = 33'($signed(t0_q));
          t1_d = 64'(sat32(66'(vx_q) + rnd_f)); sub_d = 4'd2;
        end else begin
          ma = 36'(vx_q); mb = 33'($signed(t0_q));
          vy_d = 32'(sat32(66'(vy_q) - rnd_f)); vx_d = t1_q[31:0];
          sub_d = '0; state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || out_acc) begin
          ovalid_d = 1'b1; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lim_q <= 31'd1966080;
      conv_q <= 1'b0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < NumWheels; i++) prev_q[i] <= '0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgIdxLimit) lim_q <= cfg_data_i[30:0];
        else conv_q <= cfg_data_i[0];
      end
      if (state_q == ST_OUT && state_d == ST_IDLE) begin
        for (int i = 0; i < NumWheels; i++) prev_q[i] <= ws_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ws_q <= ws_d; acc_q <= acc_d; c_q <= c_d;
    vx_q <= vx_d; vy_q <= vy_d; w_q <= w_d;
    idx_q <= idx_d; best_q <= best_d; sub_q <= sub_d;
    aclip_q <= in_acc ? 1'b0 : aclip_d;
    sclip_q <= in_acc ? 1'b0 : sclip_d;
    t0_q <= t0_d; t1_q <= t1_d; r_q <= r_d; vmax_q <= vmax_d;
    if (state_q == ST_OUT && state_d == ST_IDLE) begin
      ovx_q <= vx_q; ovy_q <= vy_q; ow_q <= w_q;
      oac_q <= aclip_q; osc_q <= sclip_q;
    end
  end

  assign out_valid_o = ovalid_q;
  assign lim_vx_o = ovx_q;
  assign lim_vy_o = ovy_q;
  assign lim_turn_o = ow_q;
  assign accel_clipped_o = oac_q;
  assign spin_clipped_o = osc_q;

`ifndef NO_ASSERTIONS
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o) else $error("transfer taken while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(lim_vx_o))
    else $error("result dropped");
  a_start_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == ST_MAP) else $error("start lost");
`endif
endmodule

FILE: src/owal_div.sv
module owal_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  owal_pkg::div_ctl_t    ctl_i,
  input  logic [63:0]           num_i,
  input  logic [63:0]           den_i,
  output logic [63:0]           quo_o,
  output logic                  busy_o
);
  import owal_pkg::*;

  logic [63:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [6:0] cnt_q, cnt_d;
  logic busy_q, busy_d;
  logic [64:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    den_d = den_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (ctl_i.start) begin
      quo_d = num_i;
      rem_d = '0;
      den_d = den_i;
      cnt_d = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign quo_o = quo_q;
  assign busy_o = busy_q | ctl_i.start;

`ifndef NO_ASSERTIONS
  a_cnt_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 7'd0) else $error("div count zero while busy");
  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == 7'd1 && !ctl_i.start) |=> !busy_q) else $error("div overrun");
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |=> busy_q && cnt_q == 7'd64) else $error("div start");
`endif
endmodule

FILE: dv/testbench.sv
module testbench;
  import owal_pkg::*;

  typedef struct {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] turn;
    logic               aclip;
    logic               sclip;
  } limited_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CfgIdxLimit;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] cmd_vx = '0;
  logic signed [31:0] cmd_vy = '0;
  logic signed [31:0] cmd_turn = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] lim_vx;
  logic signed [31:0] lim_vy;
  logic signed [31:0] lim_turn;
  logic               accel_clipped;
  logic               spin_clipped;

  longint             wheel_hist[4];
  longint unsigned    limit_reg;
  bit                 conv_en;
  limited_cmd_t       expected_q[$];
  int                 errors = 0;
  bit                 tx_idle_en = 1'b1;
  bit                 rx_idle_en = 1'b1;
  bit                 hold_req = 1'b0;
  int                 quiet_cycles = 0;

  omni_wheel_accel_limiter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_vx_i(cmd_vx), .cmd_vy_i(cmd_vy), .cmd_turn_i(cmd_turn),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .lim_vx_o(lim_vx), .lim_vy_o(lim_vy), .lim_turn_o(lim_turn),
    .accel_clipped_o(accel_clipped), .spin_clipped_o(spin_clipped)
  );

  always #1 clk = ~clk;

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned absu(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // rounded product with a 20-bit fraction constant, floor shift
  function automatic longint mul_k(input longint x, input longint k);
    return (x * k + (64'sd1 <<< (CBits - 1))) >>> CBits;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void wheels_to_body(input longint s[4], output longint vx,
                                         output longint vy, output longint w);
    w  = clamp32(mul_k(-(s[0] + s[1] + s[2] + s[3]), longint'(KInvArm4)));
    vx = clamp32(mul_k(s[0] + s[1] - s[2] - s[3], longint'(KInvDiag2)));
    vy = clamp32(mul_k(s[1] + s[2] - s[0] - s[3], longint'(KInvDiag2)));
  endfunction

  function automatic limited_cmd_t limit_command(input logic signed [31:0] cx,
                                                 input logic signed [31:0] cy,
                                                 input logic signed [31:0] ct);
    longint          a, b, t, vx, vy, w, o, d, ox, tw;
    longint          ws[4];
    longint          acc[4];
    longint unsigned mg[4];
    longint unsigned c[4];
    longint unsigned lim, h, tw3, f, nm, vmax;
    int              best;
    limited_cmd_t    r;
    lim = limit_reg;
    best = 0;
    a = mul_k(longint'(cx) - longint'(cy), longint'(KDiag));
    b = mul_k(longint'(cx) + longint'(cy), longint'(KDiag));
    t = mul_k(longint'(ct), longint'(KArm));
    ws[0] = clamp32(a - t);
    ws[1] = clamp32(b - t);
    ws[2] = clamp32(-b - t);
    ws[3] = clamp32(-a - t);
    for (int i = 0; i < 4; i++) begin
      o = wheel_hist[i];
      acc[i] = ws[i] - o;
      mg[i] = absu(acc[i]);
      c[i] = ((acc[i] < 0 && o > 0) || (acc[i] > 0 && o < 0)) ? 3 : 2;
      if (mg[i] * c[best] > mg[best] * c[i]) best = i;
    end
    r.aclip = (2 * mg[best] > c[best] * lim);
    if (r.aclip) begin
      for (int i = 0; i < 4; i++) begin
        f = (mg[i] << 30) / mg[best];
        nm = (f * c[best] * lim + (64'd1 << 30)) >> 31;
        d = longint'(nm);
        ws[i] = clamp32(wheel_hist[i] + ((acc[i] < 0) ? -d : d));
      end
    end
    wheels_to_body(ws, vx, vy, w);
    h = floor_root(longint'(vx * vx) + longint'(vy * vy));
    tw3 = (absu(w) * longint'(KSpin) + (64'd1 << (CBits - 1))) >> CBits;
    r.sclip = (h * tw3 > (lim << 16));
    if (r.sclip) begin
      vmax = lim;
      for (int i = 0; i < 4; i++) if (absu(ws[i]) > vmax) vmax = absu(ws[i]);
      if (vmax != 0) begin
        for (int i = 0; i < 4; i++) begin
          d = longint'((absu(ws[i]) * lim) / vmax);
          ws[i] = clamp32((ws[i] < 0) ? ws[i] + d : ws[i] - d);
        end
      end
      wheels_to_body(ws, vx, vy, w);
    end
    if (conv_en) begin
      ox = vx;
      tw = mul_k(w, longint'(KConv));
      vx = clamp32(vx + ((vy * tw + 64'sd32768) >>> 16));
      vy = clamp32(vy - ((ox * tw + 64'sd32768) >>> 16));
    end
    for (int i = 0; i < 4; i++) wheel_hist[i] = ws[i];
    r.vx = vx[31:0];
    r.vy = vy[31:0];
    r.turn = w[31:0];
    return r;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d", field, got, want);
    errors++;
  endtask

  // result side: check each transfer and shape the stall pattern
  always @(posedge clk) begin
    limited_cmd_t e;
    static int stall_left = 0;
    static int gap_left = 0;
    if (out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("mismatch: result with nothing expected");
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (lim_vx !== e.vx) report("lim_vx", lim_vx, e.vx);
        if (lim_vy !== e.vy) report("lim_vy", lim_vy, e.vy);
        if (lim_turn !== e.turn) report("lim_turn", lim_turn, e.turn);
        if (accel_clipped !== e.aclip) report("accel_clipped", accel_clipped, e.aclip);
        if (spin_clipped !== e.sclip) report("spin_clipped", spin_clipped, e.sclip);
      end
    end
    if (hold_req) begin
      stall_left = 600;
      hold_req = 1'b0;
    end else if (stall_left == 0 && gap_left == 0 && rx_idle_en) begin
      if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 11);
      else gap_left = $urandom_range(1, 40);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if (gap_left > 0) gap_left--;
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic cfg_write(input logic idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CfgIdxLimit) limit_reg = value[30:0];
    else conv_en = value[0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cmd(input logic signed [31:0] vx, input logic signed [31:0] vy,
                          input logic signed [31:0] turn);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd_vx <= vx;
    cmd_vy <= vy;
    cmd_turn <= turn;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(limit_command(vx, vy, turn));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2, 3: return 32'($urandom_range(0, 32'h3fffff)) - 32'h200000;
      4: return 32'($urandom_range(0, 32'h3ffff)) - 32'h20000;
      5: return 32'd0;
      default: return 32'($urandom_range(0, 32'h3ffffff)) - 32'h2000000;
    endcase
  endfunction

  function automatic logic [31:0] rand_limit();
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(1, 32'h7fffffff));
      1: return 32'($urandom_range(1, 32'h10000));
      default: return 32'($urandom_range(32'h10000, 32'h400000));
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn;
    mx = 32'sh7fffffff;
    mn = 32'sh80000000;
    send_cmd(0, 0, 0);
    send_cmd(32'sh10000, 0, 0);
    send_cmd(32'sh100000, 0, 0);
    send_cmd(0, 32'sh100000, 0);
    send_cmd(32'sh10000, 32'sh10000, 32'sh10000);
    send_cmd(-32'sh100000, 0, 0);
    send_cmd(-32'sh100000, 32'sh50000, 0);
    send_cmd(0, 0, 32'sh8000);
    send_cmd(32'sh200000, 32'sh200000, 32'sh40000);
    send_cmd(mx, mx, mx);
    send_cmd(mn, mn, mn);
    send_cmd(mx, mn, 0);
    send_cmd(mn, mx, mx);
    send_cmd(0, 0, mn);
    send_cmd(32'sh400000, -32'sh400000, 32'sh100000);
    send_cmd(32'sh400000, -32'sh400000, 32'sh100000);
    send_cmd(0, 0, 0);
    send_cmd(-1, 1, -1);
    drain();
  endtask

  task automatic test_settings();
    logic [31:0] lims[4];
    lims = '{32'd1, 32'h7fffffff, 32'h10000, 32'h1e0000};
    for (int p = 0; p < 8; p++) begin
      cfg_write(CfgIdxLimit, (p < 4) ? lims[p] : rand_limit());
      cfg_write(CfgIdxConv, p[0]);
      for (int i = 0; i < 40; i++) send_cmd(rand_field(), rand_field(), rand_field());
      drain();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 6; i++) send_cmd(rand_field(), rand_field(), rand_field());
    drain();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 199) begin
        drain();
        cfg_write(CfgIdxLimit, rand_limit());
        cfg_write(CfgIdxConv, $urandom_range(0, 1));
      end
      send_cmd(rand_field(), rand_field(), rand_field());
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) wheel_hist[i] = 0;
    limit_reg = 1966080;
    conv_en = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_settings();
    test_backpressure();
    test_random(1050);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random(150);
    repeat (500) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: omni_wheel_accel_limiter.f
src/owal_pkg.sv
src/owal_div.sv
src/omni_wheel_accel_limiter.sv
dv/testbench.sv
